### sv/first_match_prefix_acl_core_macros.svh
// Assertion helpers; expect clk and rst_n in scope.
`ifndef FIRST_MATCH_PREFIX_ACL_CORE_MACROS_SVH
`define FIRST_MATCH_PREFIX_ACL_CORE_MACROS_SVH

`define FMPA_CHECK(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define FMPA_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### sv/fmpa_pkg.sv
package fmpa_pkg;

    localparam int MAX_RULES = 64;
    localparam int CNT_W     = $clog2(MAX_RULES + 1);
    localparam int HIT_W     = 6;
    localparam int ADDR_W    = 64;
    localparam int BYTE_W    = 8;

    localparam logic [1:0] ST_ADDED = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_MATCH = 2'd2;
    localparam logic [1:0] ST_MISS  = 2'd3;

    localparam logic MODE_ADD    = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    localparam logic FAM_V4 = 1'b0;

    localparam logic [BYTE_W-1:0] V4_WIDTH = 8'd32;
    localparam logic [BYTE_W-1:0] V6_WIDTH = 8'd128;
    localparam logic [BYTE_W-1:0] HI_BITS  = 8'd64;

    typedef struct packed {
        logic              vld;
        logic              live;
        logic              fam;
        logic [ADDR_W-1:0] hi;
        logic [ADDR_W-1:0] lo;
        logic              found;
        logic [HIT_W-1:0]  idx;
        logic [BYTE_W-1:0] action;
        logic [BYTE_W-1:0] flags;
    } tok_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] hi;
        logic [ADDR_W-1:0] lo;
        logic [BYTE_W-1:0] len;
        logic [BYTE_W-1:0] action;
        logic [BYTE_W-1:0] flags;
        logic              fam;
    } rule_wr_t;

endpackage

### sv/fmpa_in_if.sv
interface fmpa_in_if;
    import fmpa_pkg::*;

    logic              valid;
    logic              ready;
    logic              mode;
    logic [ADDR_W-1:0] addr_hi;
    logic [ADDR_W-1:0] addr_lo;
    logic [1:0]        query_family;
    logic [BYTE_W-1:0] prefix_len;
    logic [BYTE_W-1:0] rule_action;
    logic [BYTE_W-1:0] rule_flags;

    modport source (
        output valid, mode, addr_hi, addr_lo, query_family, prefix_len, rule_action, rule_flags,
        input  ready
    );
    modport sink (
        input  valid, mode, addr_hi, addr_lo, query_family, prefix_len, rule_action, rule_flags,
        output ready
    );
endinterface

### sv/fmpa_out_if.sv
interface fmpa_out_if;
    import fmpa_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [HIT_W-1:0]  hit_index;
    logic [BYTE_W-1:0] hit_action;
    logic [BYTE_W-1:0] hit_flags;

    modport source (
        output valid, status, hit_index, hit_action, hit_flags,
        input  ready
    );
    modport sink (
        input  valid, status, hit_index, hit_action, hit_flags,
        output ready
    );
endinterface

### sv/fmpa_cell.sv
module fmpa_cell
    import fmpa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  rule_wr_t         wr,
    input  logic             rule_vld,
    input  logic [HIT_W-1:0] cell_idx,
    input  tok_t             tok_in,
    output tok_t             tok_out
);

    logic [ADDR_W-1:0] hi_reg;
    logic [ADDR_W-1:0] lo_reg;
    logic [BYTE_W-1:0] len_reg;
    logic [BYTE_W-1:0] act_reg;
    logic [BYTE_W-1:0] flg_reg;
    logic              fam_reg;

    logic              vld_reg;
    tok_t              tok_reg;
    tok_t              tok_next;

    logic [ADDR_W-1:0] hi_mask;
    logic [ADDR_W-1:0] lo_mask;
    logic [BYTE_W-1:0] lo_len;
    logic [BYTE_W-1:0] width;
    logic              hit;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            hi_reg  <= wr.hi;
            lo_reg  <= wr.lo;
            len_reg <= wr.len;
            act_reg <= wr.action;
            flg_reg <= wr.flags;
            fam_reg <= wr.fam;
        end
    end

    always_comb
    begin
        lo_len  = (len_reg > HI_BITS) ? (len_reg - HI_BITS) : '0;
        hi_mask = ~({ADDR_W{1'b1}} >> len_reg);
        lo_mask = ~({ADDR_W{1'b1}} >> lo_len);
        width   = (tok_in.fam == FAM_V4) ? V4_WIDTH : V6_WIDTH;
        hit     = rule_vld && tok_in.live && !tok_in.found
                  && (fam_reg == tok_in.fam) && (len_reg <= width)
                  && (((hi_reg ^ tok_in.hi) & hi_mask) == '0)
                  && (((lo_reg ^ tok_in.lo) & lo_mask) == '0);

        tok_next = tok_in;
        if (hit)
        begin
            tok_next.found  = 1'b1;
            tok_next.idx    = cell_idx;
            tok_next.action = act_reg;
            tok_next.flags  = flg_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= tok_in.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tok_reg <= tok_next;
        end
    end

    always_comb
    begin
        tok_out     = tok_reg;
        tok_out.vld = vld_reg;
    end

endmodule

### sv/first_match_prefix_acl_core.sv
// Channel | Dir | Payload
// req     | in  | mode, addr_hi, addr_lo, query_family, prefix_len, rule_action, rule_flags
// rsp     | out | status, hit_index, hit_action, hit_flags
// cfg     | in  | cfg_we, cfg_wdata (list family)
// Lookups run through a row of MAX_RULES registered cells and then the result register,
// one lookup item taken per cycle while rsp is not stalled.
// An add item is answered in the next cycle but waits until no lookup is left in the row.
// Reset empties the table and sets the list family to IPv4; no clearing pass.
// A stalled rsp holds the whole row and req.
module first_match_prefix_acl_core
    import fmpa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    fmpa_in_if.sink    req,
    fmpa_out_if.source rsp
);

    `include "first_match_prefix_acl_core_macros.svh"

    logic              fam_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;

    logic              out_vld_reg;
    logic              out_vld_next;
    logic [1:0]        out_status_reg;
    logic [1:0]        out_status_next;
    logic [HIT_W-1:0]  out_idx_reg;
    logic [HIT_W-1:0]  out_idx_next;
    logic [BYTE_W-1:0] out_act_reg;
    logic [BYTE_W-1:0] out_act_next;
    logic [BYTE_W-1:0] out_flg_reg;
    logic [BYTE_W-1:0] out_flg_next;

    tok_t              tok [0:MAX_RULES];
    logic [MAX_RULES-1:0] busy;
    logic              chain_empty;
    logic              out_free;
    logic              acc;
    logic              is_add;
    logic              full;
    rule_wr_t          wr_base;

    assign out_free    = !out_vld_reg || rsp.ready;
    assign chain_empty = ~|busy;
    assign req.ready   = out_free && ((req.mode == MODE_LOOKUP) || chain_empty);
    assign acc         = req.valid && req.ready;
    assign is_add      = acc && (req.mode == MODE_ADD);
    assign full        = cnt_reg >= CNT_W'(MAX_RULES);

    always_comb
    begin
        tok[0].vld    = acc && (req.mode == MODE_LOOKUP);
        tok[0].live   = req.query_family == {1'b0, fam_reg};
        tok[0].fam    = req.query_family[0];
        tok[0].hi     = req.addr_hi;
        tok[0].lo     = req.addr_lo;
        tok[0].found  = 1'b0;
        tok[0].idx    = '0;
        tok[0].action = '0;
        tok[0].flags  = '0;

        wr_base.en     = 1'b0;
        wr_base.hi     = req.addr_hi;
        wr_base.lo     = req.addr_lo;
        wr_base.len    = req.prefix_len;
        wr_base.action = req.rule_action;
        wr_base.flags  = req.rule_flags;
        wr_base.fam    = fam_reg;
    end

    for (genvar i = 0; i < MAX_RULES; i++)
    begin : g_cell
        rule_wr_t wr;

        always_comb
        begin
            wr    = wr_base;
            wr.en = is_add && !full && (cnt_reg == CNT_W'(i));
        end

        fmpa_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (out_free),
            .wr       (wr),
            .rule_vld (cnt_reg > CNT_W'(i)),
            .cell_idx (HIT_W'(i)),
            .tok_in   (tok[i]),
            .tok_out  (tok[i+1])
        );

        assign busy[i] = tok[i+1].vld;
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (is_add && !full)
        begin
            cnt_next = cnt_reg + 1'b1;
        end

        out_vld_next    = out_vld_reg;
        out_status_next = out_status_reg;
        out_idx_next    = out_idx_reg;
        out_act_next    = out_act_reg;
        out_flg_next    = out_flg_reg;
        if (out_free)
        begin
            out_vld_next = is_add || tok[MAX_RULES].vld;
            if (is_add)
            begin
                out_status_next = full ? ST_FULL : ST_ADDED;
                out_idx_next    = '0;
                out_act_next    = '0;
                out_flg_next    = '0;
            end
            else
            begin
                out_status_next = tok[MAX_RULES].found ? ST_MATCH : ST_MISS;
                out_idx_next    = tok[MAX_RULES].idx;
                out_act_next    = tok[MAX_RULES].action;
                out_flg_next    = tok[MAX_RULES].flags;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fam_reg     <= FAM_V4;
            cnt_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                fam_reg <= cfg_wdata;
            end
            cnt_reg     <= cnt_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_idx_reg    <= out_idx_next;
        out_act_reg    <= out_act_next;
        out_flg_reg    <= out_flg_next;
    end

    assign rsp.valid      = out_vld_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.hit_index  = out_idx_reg;
    assign rsp.hit_action = out_act_reg;
    assign rsp.hit_flags  = out_flg_reg;

    `FMPA_CHECK(a_cnt_max, cnt_reg <= CNT_W'(MAX_RULES), "rule count above table size")
    `FMPA_CHECK_NEXT(a_cnt_busy, !chain_empty, $stable(cnt_reg), "table changed under lookup")
    `FMPA_CHECK_NEXT(a_add_rsp, is_add && !full, out_vld_reg && (out_status_reg == ST_ADDED), "add not reported")

endmodule

### bench/tb_first_match_prefix_acl_core.sv
module tb_first_match_prefix_acl_core
    import fmpa_pkg::*;
();

    localparam int IDLE_LIMIT  = 4000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 190;

    localparam logic FAM_V6 = 1'b1;

    localparam logic [1:0] QF_V4    = 2'd0;
    localparam logic [1:0] QF_V6    = 2'd1;
    localparam logic [1:0] QF_OTHER = 2'd2;
    localparam logic [1:0] QF_RSVD  = 2'd3;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        logic              mode;
        logic [ADDR_W-1:0] addr_hi;
        logic [ADDR_W-1:0] addr_lo;
        logic [1:0]        query_family;
        logic [BYTE_W-1:0] prefix_len;
        logic [BYTE_W-1:0] rule_action;
        logic [BYTE_W-1:0] rule_flags;
    } acl_req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [HIT_W-1:0]  hit_index;
        logic [BYTE_W-1:0] hit_action;
        logic [BYTE_W-1:0] hit_flags;
    } acl_rsp_t;

    typedef struct {
        row_kind_t kind;
        acl_req_t  item;
        bit        typed;
        acl_rsp_t  exp;
        logic      fam;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    fmpa_in_if  req_ch ();
    fmpa_out_if rsp_ch ();

    first_match_prefix_acl_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // shadow rule table
    logic [ADDR_W-1:0] rule_hi  [MAX_RULES];
    logic [ADDR_W-1:0] rule_lo  [MAX_RULES];
    logic [BYTE_W-1:0] rule_len [MAX_RULES];
    logic [BYTE_W-1:0] rule_act [MAX_RULES];
    logic [BYTE_W-1:0] rule_flg [MAX_RULES];
    logic              rule_fam [MAX_RULES];
    int                rule_cnt;
    logic              list_fam;

    acl_rsp_t awaited_rsp [$];
    dir_row_t dir_rows [$];
    int       fail_count;
    bit       steady;
    int       boundary_lens [10] = '{31, 32, 33, 63, 64, 65, 127, 128, 129, 255};

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [127:0] lead_bits(input int n);
        if (n <= 0)
            return '0;
        if (n >= 128)
            return '1;
        return {128{1'b1}} << (128 - n);
    endfunction

    function automatic acl_rsp_t acl_apply(input acl_req_t it);
        acl_rsp_t   r;
        int         width;
        logic [127:0] m;
        r = '0;
        if (it.mode == MODE_ADD)
        begin
            if (rule_cnt >= MAX_RULES)
            begin
                r.status = ST_FULL;
                return r;
            end
            rule_hi[rule_cnt]  = it.addr_hi;
            rule_lo[rule_cnt]  = it.addr_lo;
            rule_len[rule_cnt] = it.prefix_len;
            rule_act[rule_cnt] = it.rule_action;
            rule_flg[rule_cnt] = it.rule_flags;
            rule_fam[rule_cnt] = list_fam;
            rule_cnt++;
            r.status = ST_ADDED;
            return r;
        end
        r.status = ST_MISS;
        if (rule_cnt == 0 || it.query_family != {1'b0, list_fam})
            return r;
        width = (it.query_family == QF_V4) ? 32 : 128;
        for (int i = 0; i < rule_cnt; i++)
        begin
            if (rule_fam[i] == it.query_family[0] && int'(rule_len[i]) <= width)
            begin
                m = lead_bits(int'(rule_len[i]));
                if ((({rule_hi[i], rule_lo[i]} ^ {it.addr_hi, it.addr_lo}) & m) == '0)
                begin
                    r.status     = ST_MATCH;
                    r.hit_index  = HIT_W'(i);
                    r.hit_action = rule_act[i];
                    r.hit_flags  = rule_flg[i];
                    return r;
                end
            end
        end
        return r;
    endfunction

    task automatic send_item(input acl_req_t it, input bit typed, input acl_rsp_t exp);
        int       gap;
        int       r;
        acl_rsp_t pred;
        acl_rsp_t want;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            gap = 0;
        else if (r < 88)
            gap = $urandom_range(1, 3);
        else if (r < 97)
            gap = $urandom_range(4, 12);
        else
            gap = $urandom_range(20, 50);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.mode         <= it.mode;
        req_ch.addr_hi      <= it.addr_hi;
        req_ch.addr_lo      <= it.addr_lo;
        req_ch.query_family <= it.query_family;
        req_ch.prefix_len   <= it.prefix_len;
        req_ch.rule_action  <= it.rule_action;
        req_ch.rule_flags   <= it.rule_flags;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pred = acl_apply(it);
        want = typed ? exp : pred;
        awaited_rsp = {awaited_rsp, want};
    endtask

    task automatic wait_drain();
        req_ch.valid <= 1'b0;
        while (awaited_rsp.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_family(input logic v);
        wait_drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        list_fam = v;
        repeat (2) @(posedge clk);
    endtask

    task automatic dir_item(input logic mode, input logic [63:0] hi, input logic [63:0] lo,
                            input logic [1:0] fam, input logic [7:0] len,
                            input logic [7:0] act, input logic [7:0] flg);
        dir_row_t row;
        row.kind  = ROW_ITEM;
        row.item  = {mode, hi, lo, fam, len, act, flg};
        row.typed = 1'b0;
        row.exp   = '0;
        row.fam   = FAM_V4;
        dir_rows  = {dir_rows, row};
    endtask

    task automatic dir_typed(input logic [1:0] status, input logic [5:0] idx,
                             input logic [7:0] act, input logic [7:0] flg);
        dir_rows[dir_rows.size() - 1].typed = 1'b1;
        dir_rows[dir_rows.size() - 1].exp   = {status, idx, act, flg};
    endtask

    task automatic dir_cfg(input logic v);
        dir_row_t row;
        row.kind  = ROW_CFG;
        row.item  = '0;
        row.typed = 1'b0;
        row.exp   = '0;
        row.fam   = v;
        dir_rows  = {dir_rows, row};
    endtask

    always @(posedge clk)
    begin : rsp_check
        acl_rsp_t got;
        acl_rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got = {rsp_ch.status, rsp_ch.hit_index, rsp_ch.hit_action, rsp_ch.hit_flags};
            if (awaited_rsp.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result item: status %0d index %0d action %02h flags %02h",
                             got.status, got.hit_index, got.hit_action, got.hit_flags);
            end
            else
            begin
                want = awaited_rsp.pop_front();
                if (got !== want)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"mismatch: exp status %0d index %0d action %02h flags %02h,",
                                  " got status %0d index %0d action %02h flags %02h"},
                                 want.status, want.hit_index, want.hit_action, want.hit_flags,
                                 got.status, got.hit_index, got.hit_action, got.hit_flags);
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        int idle;
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle = 0;
        else
            idle++;
        if (idle >= IDLE_LIMIT)
        begin
            $display("timeout: no item moved for %0d cycles", idle);
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin : rsp_sink
        int run;
        int stall;
        int r;
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            r = $urandom_range(0, 99);
            run = (r < 10) ? $urandom_range(100, 300) : $urandom_range(1, 8);
            rsp_ch.ready <= 1'b1;
            repeat (run) @(posedge clk);
            r = $urandom_range(0, 99);
            if (r < 80)
                stall = $urandom_range(1, 3);
            else if (r < 96)
                stall = $urandom_range(4, 12);
            else
                stall = $urandom_range(20, 60);
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clk);
        end
    end

    initial
    begin : stimulus
        acl_req_t     it;
        logic [127:0] a;
        logic [127:0] m;
        logic [127:0] rnd;
        int           r;
        int           j;
        int           k;
        int           ln;
        int           w;
        int           cand [$];
        logic         fam_now;

        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_wdata           <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.mode         <= MODE_ADD;
        req_ch.addr_hi      <= '0;
        req_ch.addr_lo      <= '0;
        req_ch.query_family <= QF_V4;
        req_ch.prefix_len   <= '0;
        req_ch.rule_action  <= '0;
        req_ch.rule_flags   <= '0;
        rule_cnt   = 0;
        list_fam   = FAM_V4;
        fail_count = 0;
        steady     = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // empty table, then a few v4 rules
        dir_item(MODE_LOOKUP, '1, '1, QF_V4, 8'h00, 8'h00, 8'h00);
        dir_typed(ST_MISS, 6'd0, 8'h00, 8'h00);
        dir_item(MODE_ADD, 64'hC0A8_0000_0000_0000, '0, QF_V4, 8'd16, 8'h11, 8'h22);
        dir_typed(ST_ADDED, 6'd0, 8'h00, 8'h00);
        dir_item(MODE_ADD, '1, '1, QF_RSVD, 8'd255, 8'hFF, 8'hFF);
        dir_typed(ST_ADDED, 6'd0, 8'h00, 8'h00);
        dir_item(MODE_ADD, 64'h0A00_0001_0000_0000, '0, QF_V4, 8'd32, 8'h33, 8'h44);
        dir_typed(ST_ADDED, 6'd0, 8'h00, 8'h00);
        dir_item(MODE_ADD, 64'h0A00_0001_8000_0000, '0, QF_V6, 8'd33, 8'h55, 8'h66);
        dir_typed(ST_ADDED, 6'd0, 8'h00, 8'h00);
        dir_item(MODE_LOOKUP, 64'hC0A8_1234_0000_0000, '0, QF_V4, 8'hFF, 8'hFF, 8'hFF);
        dir_typed(ST_MATCH, 6'd0, 8'h11, 8'h22);
        dir_item(MODE_LOOKUP, 64'h0A00_0001_FFFF_FFFF, '1, QF_V4, 8'h00, 8'h00, 8'h00);
        dir_item(MODE_LOOKUP, '1, '1, QF_V4, 8'h00, 8'h00, 8'h00);
        // wrong family and unknown family codes
        dir_item(MODE_LOOKUP, 64'hC0A8_1234_0000_0000, '0, QF_V6, 8'h00, 8'h00, 8'h00);
        dir_typed(ST_MISS, 6'd0, 8'h00, 8'h00);
        dir_item(MODE_LOOKUP, 64'hC0A8_1234_0000_0000, '0, QF_OTHER, 8'h00, 8'h00, 8'h00);
        dir_typed(ST_MISS, 6'd0, 8'h00, 8'h00);
        dir_item(MODE_LOOKUP, 64'hC0A8_1234_0000_0000, '0, QF_RSVD, 8'h00, 8'h00, 8'h00);
        dir_typed(ST_MISS, 6'd0, 8'h00, 8'h00);
        // v6 list
        dir_cfg(FAM_V6);
        dir_item(MODE_LOOKUP, 64'hC0A8_1234_0000_0000, '0, QF_V4, 8'h00, 8'h00, 8'h00);
        dir_typed(ST_MISS, 6'd0, 8'h00, 8'h00);
        dir_item(MODE_LOOKUP, '0, '0, QF_V6, 8'h00, 8'h00, 8'h00);
        dir_item(MODE_ADD, '1, '1, QF_V6, 8'd128, 8'h5A, 8'hA5);
        dir_typed(ST_ADDED, 6'd0, 8'h00, 8'h00);
        dir_item(MODE_ADD, 64'h2001_0DB8_0000_0000, '0, QF_V4, 8'd64, 8'h01, 8'h02);
        dir_item(MODE_ADD, 64'h2001_0DB8_0000_0000, 64'h8000_0000_0000_0000, QF_V6,
                 8'd65, 8'h03, 8'h04);
        dir_item(MODE_ADD, '0, '0, QF_V6, 8'd129, 8'h00, 8'h00);
        dir_item(MODE_LOOKUP, '1, '1, QF_V6, 8'h00, 8'h00, 8'h00);
        dir_item(MODE_LOOKUP, 64'h2001_0DB8_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, QF_V6,
                 8'h00, 8'h00, 8'h00);
        dir_item(MODE_LOOKUP, 64'h2001_0DB8_0000_0001, '0, QF_V6, 8'h00, 8'h00, 8'h00);
        // back to v4: old rules keep their family; zero length matches all
        dir_cfg(FAM_V4);
        dir_item(MODE_ADD, '0, '0, QF_V4, 8'd0, 8'h77, 8'h88);
        dir_typed(ST_ADDED, 6'd0, 8'h00, 8'h00);
        dir_item(MODE_LOOKUP, 64'h0A00_0001_0000_0000, '0, QF_V4, 8'h00, 8'h00, 8'h00);
        dir_item(MODE_LOOKUP, 64'h0B00_0000_0000_0000, '0, QF_V4, 8'h00, 8'h00, 8'h00);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
                set_family(dir_rows[i].fam);
            else
                send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].exp);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            if (p == 5)
                fam_now = logic'($urandom_range(0, 1));
            else
                fam_now = (p % 2 == 0) ? FAM_V6 : FAM_V4;
            set_family(fam_now);
            steady = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                it = '0;
                it.query_family = 2'($urandom_range(0, 3));
                it.prefix_len   = 8'($urandom_range(0, 255));
                it.rule_action  = 8'($urandom_range(0, 255));
                it.rule_flags   = 8'($urandom_range(0, 255));
                rnd = {$urandom, $urandom, $urandom, $urandom};
                a = rnd;
                if ($urandom_range(0, 99) < 10)
                begin
                    it.mode = MODE_ADD;
                    r = $urandom_range(0, 99);
                    if (r < 2)
                        ln = 0;
                    else if (r < 70)
                        ln = (list_fam == FAM_V6) ? $urandom_range(1, 128) : $urandom_range(1, 32);
                    else if (r < 88)
                        ln = boundary_lens[$urandom_range(0, 9)];
                    else
                        ln = $urandom_range(0, 255);
                    it.prefix_len = 8'(ln);
                    // nest under an existing prefix now and then
                    if (rule_cnt > 0 && $urandom_range(0, 99) < 30)
                    begin
                        k = $urandom_range(0, rule_cnt - 1);
                        m = lead_bits(int'(rule_len[k]));
                        a = ({rule_hi[k], rule_lo[k]} & m) | (rnd & ~m);
                    end
                end
                else
                begin
                    it.mode = MODE_LOOKUP;
                    cand.delete();
                    w = (list_fam == FAM_V6) ? 128 : 32;
                    for (k = 0; k < rule_cnt; k++)
                        if (rule_fam[k] == list_fam && int'(rule_len[k]) <= w)
                            cand = {cand, k};
                    if (cand.size() > 0 && $urandom_range(0, 99) < 70)
                    begin
                        j = cand[$urandom_range(0, cand.size() - 1)];
                        m = lead_bits(int'(rule_len[j]));
                        a = ({rule_hi[j], rule_lo[j]} & m) | (rnd & ~m);
                        // near miss: one bit flipped inside the prefix
                        if (rule_len[j] > 0 && $urandom_range(0, 9) == 0)
                        begin
                            k = 128 - $urandom_range(1, rule_len[j]);
                            a[k] = ~a[k];
                        end
                        it.query_family = {1'b0, list_fam};
                        if ($urandom_range(0, 19) == 0)
                            it.query_family = 2'($urandom_range(0, 3));
                    end
                    else if ($urandom_range(0, 99) < 70)
                        it.query_family = {1'b0, list_fam};
                end
                it.addr_hi = a[127:64];
                it.addr_lo = a[63:0];
                send_item(it, 1'b0, '0);
                if ($urandom_range(0, 199) == 0)
                    wait_drain();
            end
        end

        wait_drain();
        repeat (MAX_RULES + 16) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
